// ===== design/fvt_pkg.sv =====
// Shared types and constants of the violation table.
package fvt_pkg;

   localparam logic [9:0]  MS_PER_S   = 10'd1000;
   localparam logic [15:0] MS_PER_MIN = 16'd60000;

   localparam int CSR_AW = 4;

   localparam logic [1:0] REG_BAN_MINUTES  = 2'd0;
   localparam logic [1:0] REG_BAN_THRESH   = 2'd1;
   localparam logic [1:0] REG_PENALTY_MODE = 2'd2;

   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_ADD   = 1'b1;

   typedef struct packed {
      logic [10:0] ban_minutes;
      logic [7:0]  ban_threshold;
      logic        penalty_mode;
   } cfg_type;

   // One table entry as held in memory; penalty lifetimes are kept in ms.
   typedef struct packed {
      logic        valid;
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] stamp;
      logic [7:0]  count;
      logic        is_penalty;
      logic [31:0] life_ms;
   } entry_type;

   typedef struct packed {
      logic       found;
      logic       inserted;
      logic       table_full;
      logic       over_limit;
      logic [7:0] entry_count;
   } rsp_type;

endpackage

// ===== design/failban_violation_table_unit.sv =====
// Top level of the address and port violation table with expiry.
//
// An item is taken when start is high and busy low. With the table active the
// scan reads one entry per cycle through the memory read port, checks it for
// expiry and match and, if it expired or its count rises, writes it back the
// next cycle; then the finish state settles the insert. With ban_minutes and
// penalty mode both zero the result comes the cycle after the start. rsp_valid
// marks a result for exactly one cycle and cannot be held off. After reset a
// clearing pass over every entry keeps busy high; register writes are taken
// throughout.
module failban_violation_table_unit
   import fvt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [31:0]       req_client_ip,
   input  logic [15:0]       req_client_port,
   input  logic [15:0]       req_penalty_seconds,
   input  logic [31:0]       req_now_ms,
   output logic              rsp_valid,
   output logic              rsp_found,
   output logic              rsp_inserted,
   output logic              rsp_table_full,
   output logic              rsp_over_limit,
   output logic [7:0]        rsp_entry_count,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   cfg_type       cfg;
   rsp_type       rsp;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   entry_type     mem_rdata;

   fvt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fvt_table_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   fvt_scan #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .start           (start),
      .busy            (busy),
      .operation       (req_operation),
      .client_ip       (req_client_ip),
      .client_port     (req_client_port),
      .penalty_seconds (req_penalty_seconds),
      .now_ms          (req_now_ms),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_re          (mem_re),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata),
      .rsp_valid       (rsp_valid),
      .rsp             (rsp)
   );

   assign rsp_found       = rsp.found;
   assign rsp_inserted    = rsp.inserted;
   assign rsp_table_full  = rsp.table_full;
   assign rsp_over_limit  = rsp.over_limit;
   assign rsp_entry_count = rsp.entry_count;

   // an insert never reports a match nor a full table
   a_insert_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inserted |-> !rsp_found && !rsp_table_full)
      else $error("insert reported with match or full table");

   a_over_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> !rsp_over_limit)
      else $error("over_limit without a match");

   // the memory never sees a read and a write of one entry in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("read and write of the same entry overlap");

   a_rsp_after_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result without an item in flight");

endmodule

// ===== design/fvt_csr.sv =====
// Configuration registers behind the APB-style port.
module fvt_csr
   import fvt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   logic    wr_beat;

   assign pready  = 1'b1;
   assign wr_beat = psel & penable & pwrite & pready;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_beat) begin
         case (paddr[3:2])
            REG_BAN_MINUTES:  cfg_ff.ban_minutes   <= pwdata[10:0];
            REG_BAN_THRESH:   cfg_ff.ban_threshold <= pwdata[7:0];
            REG_PENALTY_MODE: cfg_ff.penalty_mode  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_BAN_MINUTES:  prdata = {21'd0, cfg_ff.ban_minutes};
         REG_BAN_THRESH:   prdata = {24'd0, cfg_ff.ban_threshold};
         REG_PENALTY_MODE: prdata = {31'd0, cfg_ff.penalty_mode};
         default:          prdata = '0;
      endcase
   end

endmodule

// ===== design/fvt_table_mem.sv =====
// Entry memory: one write port, one read port, registered read data.
module fvt_table_mem
   import fvt_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  entry_type     wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output entry_type     rdata
);

   entry_type mem_ff [DEPTH];
   entry_type rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

// ===== design/fvt_scan.sv =====
// Sequencer: clearing pass, per-item scan with expiry and match, insert.
module fvt_scan
   import fvt_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          start,
   output logic          busy,
   input  logic          operation,
   input  logic [31:0]   client_ip,
   input  logic [15:0]   client_port,
   input  logic [15:0]   penalty_seconds,
   input  logic [31:0]   now_ms,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output entry_type     mem_wdata,
   output logic          mem_re,
   output logic [AW-1:0] mem_raddr,
   input  entry_type     mem_rdata,
   output logic          rsp_valid,
   output rsp_type       rsp
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] eval_addr_ff, eval_addr_in;
   logic          found_ff, found_in;
   logic          over_ff, over_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic          op_ff, op_in;
   logic [31:0]   ip_ff, ip_in;
   logic [15:0]   port_ff, port_in;
   logic [15:0]   pen_ff, pen_in;
   logic [31:0]   now_ff, now_in;
   logic [31:0]   pen_ms_ff, pen_ms_in;
   logic [31:0]   life_ms_ff, life_ms_in;
   logic [7:0]    thr_ff, thr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [31:0] age;
   logic [31:0] limit;
   logic        expired;
   logic        live;
   logic        hit;
   logic        over_e;
   logic        bump;
   logic [7:0]  ins_count;
   entry_type   ins_entry;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // expiry and match of the entry read in the previous cycle
   always_comb begin
      age     = now_ff - mem_rdata.stamp;
      limit   = mem_rdata.is_penalty ? mem_rdata.life_ms : life_ms_ff;
      expired = mem_rdata.valid && !age[31] && (age >= limit);
      live    = mem_rdata.valid && !expired;
      hit     = live && (mem_rdata.ip == ip_ff) && (mem_rdata.port == port_ff);
      over_e  = (mem_rdata.count >= thr_ff);
      bump    = hit && (op_ff == OP_CHECK) && !over_e;

      ins_count            = (pen_ff != 16'd0)
                             ? ((thr_ff == 8'hFF) ? 8'hFF : thr_ff + 8'd1) : 8'd1;
      ins_entry.valid      = 1'b1;
      ins_entry.ip         = ip_ff;
      ins_entry.port       = port_ff;
      ins_entry.stamp      = now_ff;
      ins_entry.count      = ins_count;
      ins_entry.is_penalty = (pen_ff != 16'd0);
      ins_entry.life_ms    = pen_ms_ff;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      eval_addr_in  = eval_addr_ff;
      found_in      = found_ff;
      over_in       = over_ff;
      cnt_in        = cnt_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      op_in         = op_ff;
      ip_in         = ip_ff;
      port_in       = port_ff;
      pen_in        = pen_ff;
      now_in        = now_ff;
      pen_ms_in     = pen_ms_ff;
      life_ms_in    = life_ms_ff;
      thr_in        = thr_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = eval_addr_ff;
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = idx_ff[AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = '0;
            if (idx_ff == CW'(DEPTH - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               if ((cfg.ban_minutes != 11'd0) || cfg.penalty_mode) begin
                  op_in         = operation;
                  ip_in         = client_ip;
                  port_in       = client_port;
                  pen_in        = penalty_seconds;
                  now_in        = now_ms;
                  pen_ms_in     = 32'(penalty_seconds) * 32'(MS_PER_S);
                  life_ms_in    = 32'(cfg.ban_minutes) * 32'(MS_PER_MIN);
                  thr_in        = cfg.ban_threshold;
                  found_in      = 1'b0;
                  over_in       = 1'b0;
                  cnt_in        = 8'd0;
                  free_found_in = 1'b0;
                  idx_in        = '0;
                  state_in      = ST_SCAN;
               end else begin
                  // table inactive: answer at once with all fields clear
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               mem_we          = expired || bump;
               mem_wdata.valid = live;
               mem_wdata.count = bump ? mem_rdata.count + 8'd1 : mem_rdata.count;
               if (!live && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = eval_addr_ff;
               end
               if (hit) begin
                  found_in = 1'b1;
                  over_in  = over_e;
                  cnt_in   = bump ? mem_rdata.count + 8'd1 : mem_rdata.count;
               end
            end
            // read of entry k overlaps the write-back of entry k-1
            if (idx_ff != CW'(DEPTH)) begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               eval_addr_in = idx_ff[AW-1:0];
               idx_in       = idx_ff + CW'(1);
            end else if (!pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in       = 1'b1;
            rsp_in.found       = found_ff;
            rsp_in.over_limit  = over_ff;
            rsp_in.inserted    = 1'b0;
            rsp_in.table_full  = 1'b0;
            rsp_in.entry_count = cnt_ff;
            if ((op_ff == OP_ADD) && !found_ff) begin
               if (free_found_ff) begin
                  mem_we             = 1'b1;
                  mem_waddr          = free_idx_ff;
                  mem_wdata          = ins_entry;
                  rsp_in.inserted    = 1'b1;
                  rsp_in.entry_count = ins_count;
               end else begin
                  rsp_in.table_full = 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         over_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         over_ff       <= over_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      eval_addr_ff <= eval_addr_in;
      cnt_ff       <= cnt_in;
      free_idx_ff  <= free_idx_in;
      op_ff        <= op_in;
      ip_ff        <= ip_in;
      port_ff      <= port_in;
      pen_ff       <= pen_in;
      now_ff       <= now_in;
      pen_ms_ff    <= pen_ms_in;
      life_ms_ff   <= life_ms_in;
      thr_ff       <= thr_in;
      rsp_ff       <= rsp_in;
   end

endmodule
